/* hdl/message_resequencer_dedup_assert.svh */
// Assertion macros shared by the checker of the message resequencer.
// Needs nothing else; the including file supplies clock, reset and signals.
`ifndef MESSAGE_RESEQUENCER_DEDUP_ASSERT_SVH
`define MESSAGE_RESEQUENCER_DEDUP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("message resequencer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("message resequencer check failed in the following cycle");

`endif

/* hdl/mrd_pkg.sv */
// Types and codes of the message resequencer and duplicate filter.
// Used by the top level and by its port checker; depends on nothing.
`timescale 1ns / 1ps

package mrd_pkg;

  typedef enum logic [2:0] {
    ST_DELIVERED = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_HELD      = 3'd2,
    ST_STALE     = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_CLEAR     = 5'b00001,
    S_IDLE      = 5'b00010,
    S_LOOKUP    = 5'b00100,
    S_DRAIN_RD  = 5'b01000,
    S_DRAIN_OUT = 5'b10000
  } state_e;

endpackage

/* hdl/mrd_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the delivered-id map and the held payload store.
`timescale 1ns / 1ps

module mrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/message_resequencer_dedup.sv */
// Top level of the message resequencer and duplicate filter.
// Depends on mrd_pkg and on mrd_ram for the delivered-id map and payload store.
//
//  channel | direction | handshake              | payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_in_order_i
//  in      | in        | in_valid_i/in_ready_o   | msg_id_i, msg_payload_i
//  out     | out       | out_valid_o/out_ready_i | out_id_o, out_payload_o, status_o, last_o
//
// An input transaction is accepted with the map read, then looked up in S_LOOKUP
// on the registered map data. Each further delivery drained from the hold window
// passes S_DRAIN_RD, the registered read of the payload store, then S_DRAIN_OUT.
// After reset a clearing pass writes the map one id per cycle, every id in turn,
// with in_ready_o low; configuration writes are taken throughout.
// A stalled output register holds the sequencer in S_LOOKUP or S_DRAIN_OUT, with in_ready_o low.
`timescale 1ns / 1ps

module message_resequencer_dedup #(
  parameter int HOLD_DEPTH   = 32,
  parameter int ID_BITS      = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic                    cfg_in_order_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ID_BITS-1:0]      msg_id_i,
  input  logic [PAYLOAD_BITS-1:0] msg_payload_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [ID_BITS-1:0]      out_id_o,
  output logic [PAYLOAD_BITS-1:0] out_payload_o,
  output logic [2:0]              status_o,
  output logic                    last_o
);

  localparam int SLOT_W = $clog2(HOLD_DEPTH);
  localparam int CNT_W  = $clog2(HOLD_DEPTH + 1);
  localparam int MAP_DEPTH = 1 << ID_BITS;

  mrd_pkg::state_e state_q, state_d;

  logic                    in_order_q;
  logic [ID_BITS-1:0]      clr_q, clr_d;
  logic [ID_BITS-1:0]      expected_q, expected_d;
  logic [SLOT_W-1:0]       head_q, head_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [HOLD_DEPTH-1:0]   held_valid_q, held_valid_d;
  logic [ID_BITS-1:0]      id_q;
  logic [PAYLOAD_BITS-1:0] payload_q;

  logic                    out_valid_q;
  logic [ID_BITS-1:0]      out_id_q, out_id_d;
  logic [PAYLOAD_BITS-1:0] out_payload_q, out_payload_d;
  logic [2:0]              status_q, status_d;
  logic                    last_q, last_d;
  logic                    emit;
  logic                    out_free;

  logic                    map_we;
  logic [ID_BITS-1:0]      map_waddr;
  logic [0:0]              map_wdata;
  logic                    map_re;
  logic [0:0]              map_rdata;

  logic                    pay_we;
  logic                    pay_re;
  logic [PAYLOAD_BITS-1:0] pay_rdata;

  logic [ID_BITS-1:0]      gap;
  logic                    in_window;
  logic [SLOT_W:0]         slot_sum;
  logic [SLOT_W-1:0]       slot;
  logic [SLOT_W-1:0]       head_next;
  logic [CNT_W-1:0]        cnt_next;
  logic                    dup;
  logic                    run_end;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == mrd_pkg::S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  assign gap       = id_q - expected_q;
  assign in_window = gap < ID_BITS'(HOLD_DEPTH);
  assign slot_sum  = {1'b0, head_q} + {1'b0, gap[SLOT_W-1:0]};
  assign slot      = (slot_sum >= (SLOT_W+1)'(HOLD_DEPTH)) ?
                     SLOT_W'(slot_sum - (SLOT_W+1)'(HOLD_DEPTH)) : slot_sum[SLOT_W-1:0];
  assign head_next = (head_q == SLOT_W'(HOLD_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign cnt_next  = cnt_q + 1'b1;
  assign dup       = map_rdata[0] || (in_window && held_valid_q[slot]);
  assign run_end   = (cnt_next >= CNT_W'(HOLD_DEPTH)) || !held_valid_q[head_next];

  assign map_re = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    expected_d    = expected_q;
    head_d        = head_q;
    cnt_d         = cnt_q;
    held_valid_d  = held_valid_q;
    emit          = 1'b0;
    out_id_d      = id_q;
    out_payload_d = '0;
    status_d      = mrd_pkg::ST_DELIVERED;
    last_d        = 1'b1;
    map_we        = 1'b0;
    map_waddr     = id_q;
    map_wdata     = 1'b1;
    pay_we        = 1'b0;
    pay_re        = 1'b0;
    case (state_q)
      mrd_pkg::S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = 1'b0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = mrd_pkg::S_IDLE;
        end
      end
      mrd_pkg::S_IDLE: begin
        if (map_re) begin
          state_d = mrd_pkg::S_LOOKUP;
        end
      end
      mrd_pkg::S_LOOKUP: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = mrd_pkg::S_IDLE;
          if (dup) begin
            status_d = mrd_pkg::ST_DUPLICATE;
          end else if (!in_order_q) begin
            map_we        = 1'b1;
            out_payload_d = payload_q;
          end else if (gap != '0) begin
            if (gap[ID_BITS-1]) begin
              status_d = mrd_pkg::ST_STALE;
            end else if (!in_window) begin
              status_d = mrd_pkg::ST_OVERFLOW;
            end else begin
              status_d           = mrd_pkg::ST_HELD;
              pay_we             = 1'b1;
              held_valid_d[slot] = 1'b1;
            end
          end else begin
            map_we               = 1'b1;
            out_payload_d        = payload_q;
            held_valid_d[head_q] = 1'b0;
            expected_d           = expected_q + 1'b1;
            head_d               = head_next;
            cnt_d                = CNT_W'(1);
            last_d               = !held_valid_q[head_next];
            if (held_valid_q[head_next]) begin
              state_d = mrd_pkg::S_DRAIN_RD;
            end
          end
        end
      end
      mrd_pkg::S_DRAIN_RD: begin
        pay_re  = 1'b1;
        state_d = mrd_pkg::S_DRAIN_OUT;
      end
      mrd_pkg::S_DRAIN_OUT: begin
        if (out_free) begin
          emit                 = 1'b1;
          out_id_d             = expected_q;
          out_payload_d        = pay_rdata;
          last_d               = run_end;
          map_we               = 1'b1;
          map_waddr            = expected_q;
          held_valid_d[head_q] = 1'b0;
          expected_d           = expected_q + 1'b1;
          head_d               = head_next;
          cnt_d                = cnt_next;
          state_d              = run_end ? mrd_pkg::S_IDLE : mrd_pkg::S_DRAIN_RD;
        end
      end
      default: begin
        state_d = mrd_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mrd_pkg::S_CLEAR;
      in_order_q   <= 1'b1;
      clr_q        <= '0;
      expected_q   <= '0;
      head_q       <= '0;
      cnt_q        <= '0;
      held_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      expected_q   <= expected_d;
      head_q       <= head_d;
      cnt_q        <= cnt_d;
      held_valid_q <= held_valid_d;
      if (cfg_valid_i) begin
        in_order_q <= cfg_in_order_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_re) begin
      id_q      <= msg_id_i;
      payload_q <= msg_payload_i;
    end
    if (emit) begin
      out_id_q      <= out_id_d;
      out_payload_q <= out_payload_d;
      status_q      <= status_d;
      last_q        <= last_d;
    end
  end

  mrd_ram #(
    .WIDTH(1),
    .DEPTH(MAP_DEPTH)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (map_we),
    .waddr_i(map_waddr),
    .wdata_i(map_wdata),
    .re_i   (map_re),
    .raddr_i(msg_id_i),
    .rdata_o(map_rdata)
  );

  mrd_ram #(
    .WIDTH(PAYLOAD_BITS),
    .DEPTH(HOLD_DEPTH)
  ) u_pay_ram (
    .clk_i  (clk_i),
    .we_i   (pay_we),
    .waddr_i(slot),
    .wdata_i(payload_q),
    .re_i   (pay_re),
    .raddr_i(head_q),
    .rdata_o(pay_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign out_id_o      = out_id_q;
  assign out_payload_o = out_payload_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

endmodule

/* hdl/mrd_checker.sv */
// Port checker of the message resequencer, bound to the top level.
// Depends on mrd_pkg and on the assertion macros in the header file.
`timescale 1ns / 1ps
`include "message_resequencer_dedup_assert.svh"

module mrd_checker #(
  parameter int ID_BITS      = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [ID_BITS-1:0]      out_id_o,
  input logic [PAYLOAD_BITS-1:0] out_payload_o,
  input logic [2:0]              status_o,
  input logic                    last_o
);

  // A stalled result keeps its id and status.
  `MRD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_id_o) && $stable(status_o))

  // Only a delivery carries a payload; every other status shows a zero payload.
  `MRD_ASSERT_NOW(a_zero_payload, clk_i, rst_ni, out_valid_o && (status_o != mrd_pkg::ST_DELIVERED), out_payload_o == '0)

  // A status result is always the only result of its transaction.
  `MRD_ASSERT_NOW(a_status_last, clk_i, rst_ni, out_valid_o && (status_o != mrd_pkg::ST_DELIVERED), last_o)

  // An accepted transaction always goes through its lookup before the next one is accepted.
  `MRD_ASSERT_NEXT(a_one_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule

bind message_resequencer_dedup mrd_checker #(
  .ID_BITS(ID_BITS),
  .PAYLOAD_BITS(PAYLOAD_BITS)
) u_mrd_checker (.*);

/* sim/message_resequencer_dedup_test.sv */
// Self-checking testbench for message_resequencer_dedup, ordered and unordered modes.
// Depends on mrd_pkg and the block's RTL; a built-in predictor checks every result.
`timescale 1ns / 1ps

module message_resequencer_dedup_test;

  localparam int HOLD_DEPTH = 32;
  localparam int ID_W = 16;
  localparam int PL_W = 32;
  localparam int SLOT_W = $clog2(HOLD_DEPTH);
  localparam logic [ID_W-1:0] ID_HALF = ID_W'(1 << (ID_W - 1));
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int RX_HOLD_CYCLES = 400;

  typedef struct {
    logic [ID_W-1:0] id;
    logic [PL_W-1:0] payload;
    bit              after_drain;
  } msg_t;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [PL_W-1:0]  payload;
    mrd_pkg::status_e status;
    logic             last;
  } outcome_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic            cfg_in_order_i = 1'b1;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [ID_W-1:0] msg_id_i = '0;
  logic [PL_W-1:0] msg_payload_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [ID_W-1:0] out_id_o;
  logic [PL_W-1:0] out_payload_o;
  logic [2:0]      status_o;
  logic            last_o;

  msg_t     inbox_q[$];
  outcome_t outcome_q[$];

  // Predictor state.
  bit                in_order = 1'b1;
  logic [ID_W-1:0]   seq_next = '0;
  bit                seen_map [0:(1<<ID_W)-1];
  bit                hold_vld [0:HOLD_DEPTH-1];
  logic [PL_W-1:0]   hold_data [0:HOLD_DEPTH-1];
  logic [SLOT_W-1:0] hold_head = '0;

  int              failures = 0;
  int              idle_cycles = 0;
  int              tx_idle_pct = 0;
  int              rx_stall_pct = 0;
  bit              rx_hold_req = 1'b0;
  bit              rx_hold_done = 1'b0;
  int              rx_hold_left = 0;
  logic [ID_W-1:0] gen_next = '0;

  message_resequencer_dedup #(
    .HOLD_DEPTH  (HOLD_DEPTH),
    .ID_BITS     (ID_W),
    .PAYLOAD_BITS(PL_W)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_in_order_i(cfg_in_order_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .msg_id_i      (msg_id_i),
    .msg_payload_i (msg_payload_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_id_o      (out_id_o),
    .out_payload_o (out_payload_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void push_outcome(input logic [ID_W-1:0] id, input logic [PL_W-1:0] payload,
                                       input mrd_pkg::status_e status, input logic last);
    outcome_t o;
    o.id = id;
    o.payload = payload;
    o.status = status;
    o.last = last;
    outcome_q.insert(outcome_q.size(), o);
  endfunction

  function automatic void resequence_msg(input logic [ID_W-1:0] id,
                                         input logic [PL_W-1:0] payload);
    logic [ID_W-1:0]   gap;
    logic [SLOT_W-1:0] slot;
    logic              in_win;
    mrd_pkg::status_e  st;
    int                run;
    gap = id - seq_next;
    slot = hold_head + gap[SLOT_W-1:0];
    in_win = gap < ID_W'(HOLD_DEPTH);
    if (seen_map[id] || (in_win && hold_vld[slot])) begin
      push_outcome(id, '0, mrd_pkg::ST_DUPLICATE, 1'b1);
    end else if (!in_order) begin
      seen_map[id] = 1'b1;
      push_outcome(id, payload, mrd_pkg::ST_DELIVERED, 1'b1);
    end else if (gap != '0) begin
      if (gap >= ID_HALF) begin
        st = mrd_pkg::ST_STALE;
      end else if (!in_win) begin
        st = mrd_pkg::ST_OVERFLOW;
      end else begin
        hold_vld[slot] = 1'b1;
        hold_data[slot] = payload;
        st = mrd_pkg::ST_HELD;
      end
      push_outcome(id, '0, st, 1'b1);
    end else begin
      // The expected id goes out first, then every consecutive held id.
      run = 0;
      do begin
        seen_map[seq_next] = 1'b1;
        hold_vld[hold_head] = 1'b0;
        push_outcome(seq_next, (run == 0) ? payload : hold_data[hold_head],
                     mrd_pkg::ST_DELIVERED, 1'b0);
        run++;
        seq_next++;
        hold_head++;
      end while (run < HOLD_DEPTH && hold_vld[hold_head]);
      outcome_q[outcome_q.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin : sender_p
    msg_t nxt;
    bit   offer;
    if (in_valid_i && in_ready_o) begin
      resequence_msg(msg_id_i, msg_payload_i);
    end
    if (!in_valid_i || in_ready_o) begin
      offer = rst_ni && inbox_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct;
      if (offer && inbox_q[0].after_drain && outcome_q.size() != 0) begin
        offer = 1'b0;
      end
      if (offer) begin
        nxt = inbox_q[0];
        inbox_q.delete(0);
        in_valid_i <= 1'b1;
        msg_id_i <= nxt.id;
        msg_payload_i <= nxt.payload;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : receiver_p
    outcome_t want;
    if (out_valid_o && out_ready_i) begin
      if (outcome_q.size() == 0) begin
        $error("result with no transaction pending: id %h status %0d", out_id_o, status_o);
        failures++;
      end else begin
        want = outcome_q[0];
        outcome_q.delete(0);
        if (out_id_o !== want.id) begin
          $error("out_id: expected %h, got %h", want.id, out_id_o);
          failures++;
        end
        if (out_payload_o !== want.payload) begin
          $error("out_payload: expected %h, got %h", want.payload, out_payload_o);
          failures++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          failures++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          failures++;
        end
      end
    end
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req && !rx_hold_done) begin
      out_ready_i <= 1'b0;
      rx_hold_left <= RX_HOLD_CYCLES;
      rx_hold_done <= 1'b1;
    end else begin
      out_ready_i <= $urandom_range(99, 0) >= rx_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_msg(input logic [ID_W-1:0] id, input logic [PL_W-1:0] payload,
                           input bit after_drain);
    msg_t m;
    m.id = id;
    m.payload = payload;
    m.after_drain = after_drain;
    inbox_q.insert(inbox_q.size(), m);
  endtask

  task automatic wait_idle();
    while (inbox_q.size() != 0 || in_valid_i || outcome_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit mode);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_in_order_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    in_order = mode;
  endtask

  task automatic set_phase(input bit mode, input int tx_pct, input int rx_pct);
    wait_idle();
    write_mode(mode);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Sends ids gen_next .. gen_next+k-1 in shuffled order, mixed with noise.
  task automatic queue_window_burst(input int k, input bit base_last, input bit drain_first,
                                    inout int queued);
    logic [ID_W-1:0] ids[$];
    logic [ID_W-1:0] tmp;
    int              i;
    int              j;
    for (i = base_last ? 1 : 0; i < k; i++) begin
      ids.insert(ids.size(), gen_next + ID_W'(i));
    end
    for (i = ids.size() - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = ids[i];
      ids[i] = ids[j];
      ids[j] = tmp;
    end
    if (base_last) begin
      ids.insert(ids.size(), gen_next);
    end
    foreach (ids[n]) begin
      if ($urandom_range(3, 0) == 0) begin
        case ($urandom_range(2, 0))
          0: tmp = gen_next + ID_W'(k) - 1'b1 - ID_W'($urandom_range(40, 0));
          1: tmp = gen_next + ID_W'(64 + $urandom_range(16'h7000, 0));
          default: tmp = gen_next + ID_W'(64 + $urandom_range(16'hFF80, 0));
        endcase
        queue_msg(tmp, $urandom, 1'b0);
        queued++;
      end
      queue_msg(ids[n], $urandom, drain_first && n == 0);
      queued++;
    end
    gen_next += ID_W'(k);
  endtask

  task automatic ordered_phase(input int n_items, input bit with_pause);
    int queued;
    int k;
    bit pause_now;
    queued = 0;
    while (queued < n_items || with_pause) begin
      k = ($urandom_range(7, 0) == 0) ? $urandom_range(HOLD_DEPTH, 13) : $urandom_range(12, 1);
      pause_now = with_pause && queued > n_items / 2;
      queue_window_burst(k, 1'($urandom_range(1, 0)), pause_now, queued);
      if (pause_now) begin
        with_pause = 1'b0;
      end
    end
  endtask

  // Ids behind the ordered window, so ordered delivery never meets them.
  task automatic unordered_phase(input int n_items);
    logic [ID_W-1:0] prev_id;
    int              i;
    prev_id = gen_next - 1'b1;
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(4, 0) != 0) begin
        prev_id = gen_next - ID_W'($urandom_range(16'h7000, 1));
      end
      queue_msg(prev_id, $urandom, 1'b0);
    end
  endtask

  initial begin : stimulus_p
    int queued;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_phase(1'b1, 0, 0);
    queue_msg(16'd0, 32'hFFFF_FFFF, 1'b0);
    queue_msg(16'd2, 32'h0000_0000, 1'b0);
    queue_msg(16'd1, 32'hA5A5_A5A5, 1'b0);
    queue_msg(16'd1, 32'h5A5A_5A5A, 1'b0);
    queue_msg(16'hFFFF, 32'h1234_5678, 1'b0);
    queue_msg(16'h8002, 32'hFFFF_FFFF, 1'b0);
    queue_msg(16'h8003, 32'h0F0F_0F0F, 1'b0);
    queue_msg(16'd35, 32'hF0F0_F0F0, 1'b0);
    queue_msg(16'd34, 32'hDEAD_BEEF, 1'b0);
    queue_msg(16'd34, 32'h0BAD_F00D, 1'b0);
    queue_msg(16'd4, 32'h8000_0001, 1'b0);

    // Held entries must survive a stretch of unordered operation.
    set_phase(1'b0, 0, 0);
    queue_msg(16'd4, 32'h1111_1111, 1'b0);
    queue_msg(16'h9000, 32'h7FFF_FFFE, 1'b0);
    queue_msg(16'h9000, 32'h2222_2222, 1'b0);
    queue_msg(16'h7FFF, 32'h0000_0000, 1'b0);

    set_phase(1'b1, 0, 0);
    queue_msg(16'd3, 32'hCAFE_0003, 1'b0);
    gen_next = 16'd5;

    set_phase(1'b1, 0, 0);
    queued = 0;
    queue_window_burst(HOLD_DEPTH, 1'b1, 1'b0, queued);
    ordered_phase(20, 1'b0);

    set_phase(1'b1, 88, 0);
    ordered_phase(30, 1'b0);

    set_phase(1'b0, 0, 88);
    unordered_phase(30);

    set_phase(1'b1, 0, 88);
    ordered_phase(30, 1'b0);

    set_phase(1'b1, 17, 17);
    ordered_phase(30, 1'b0);

    set_phase(1'b0, 0, 0);
    unordered_phase(20);

    set_phase(1'b1, 0, 0);
    rx_hold_req = 1'b1;
    ordered_phase(30, 1'b1);

    // Delivering the expected id while unordered leaves ordered delivery stuck on it.
    set_phase(1'b0, 0, 0);
    queue_msg(gen_next, $urandom, 1'b0);
    set_phase(1'b1, 0, 0);
    queue_msg(gen_next, $urandom, 1'b0);
    queue_msg(gen_next + 1'b1, $urandom, 1'b0);
    queue_msg(gen_next + 1'b1, $urandom, 1'b0);
    queue_msg(gen_next + 16'd40, $urandom, 1'b0);
    queue_msg(gen_next + ID_HALF, $urandom, 1'b0);

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* message_resequencer_dedup.f */
+incdir+hdl
hdl/mrd_pkg.sv
hdl/mrd_ram.sv
hdl/message_resequencer_dedup.sv
hdl/mrd_checker.sv
sim/message_resequencer_dedup_test.sv
